/* hw/rtl/stbs_pkg.sv */
// Shared widths and operation codes for the sorted-table binary search core.
package stbs_pkg;

    // Fixed field widths of the item, result and configuration payloads.
    localparam int OP_W    = 1;
    localparam int IDX_W   = 10;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 11;

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

endpackage

/* hw/rtl/stbs_table_ram.sv */
// Table memory: one write port and one read port with registered read data.
module stbs_table_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [ADDR_W-1:0]                    i_wr_addr,
    input  logic signed [stbs_pkg::VALUE_W-1:0]  i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [ADDR_W-1:0]                    i_rd_addr,
    output logic signed [stbs_pkg::VALUE_W-1:0]  o_rd_data
);
    import stbs_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/sorted_table_binary_search_core.sv */
// Top level: table writes and binary search over a sorted table in memory.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   operation, entry_index, entry_value,
//                                                  search_key
//  output    out        o_out_valid / i_out_stall found, found_index
//  config    in         i_cfg_wr_en               i_cfg_wr_data (entry_count)
//
// A write item is done at its transfer and gives no result. A search is taken at its transfer;
// each probe is a memory read (S_PROBE) and then a compare (S_CMP), a miss ends in a further
// S_PROBE that sees the bounds cross, and S_DONE hands the result over. The single memory
// read port sets this pace. One item is worked on at a time.
// Reset is synchronous and active low; the table contents are not cleared.
// The finished result sits in an output register, so a new item is taken while
// the result waits; a further result waits in the core until that register frees.
module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration.
    input  logic                                 i_cfg_wr_en,
    input  logic [stbs_pkg::CFG_W-1:0]           i_cfg_wr_data,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [stbs_pkg::OP_W-1:0]            i_operation,
    input  logic [stbs_pkg::IDX_W-1:0]           i_entry_index,
    input  logic signed [stbs_pkg::VALUE_W-1:0]  i_entry_value,
    input  logic signed [stbs_pkg::VALUE_W-1:0]  i_search_key,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    output logic [stbs_pkg::IDX_W-1:0]           o_found_index
);
    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    // Signed bound width: low reaches TABLE_DEPTH, high reaches minus one.
    localparam int BW = AW + 2;
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [CFG_W-1:0]           r_entry_count;
    logic signed [BW-1:0]       r_low;
    logic signed [BW-1:0]       r_high;
    logic [AW-1:0]              r_mid;
    logic signed [VALUE_W-1:0]  r_key;
    logic                       r_res_found;
    logic [IDX_W-1:0]           r_res_index;
    logic                       r_out_valid;
    logic                       r_found;
    logic [IDX_W-1:0]           r_found_index;

    logic                       n_in_accept;
    logic [CW-1:0]              n_count_ext;
    logic [CW-1:0]              n_count_sat;
    logic [AW+1:0]              n_sum;
    logic [AW-1:0]              n_mid;
    logic                       n_wr_en;
    logic                       n_rd_en;
    logic signed [VALUE_W-1:0]  n_rd_data;
    logic                       n_out_free;

    // Handshake decode.
    assign n_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign n_out_free  = !r_out_valid || !i_out_stall;

    // Entry count saturated to the table depth.
    assign n_count_ext = CW'(r_entry_count);
    assign n_count_sat = (n_count_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : n_count_ext;

    // Midpoint of the bounds; both are non-negative whenever a probe is issued.
    assign n_sum = {1'b0, r_low[AW:0]} + {1'b0, r_high[AW:0]};
    assign n_mid = n_sum[AW:1];

    // Memory accesses: writes at transfer, reads while probing.
    assign n_wr_en = n_in_accept && (t_op'(i_operation) == OP_WRITE)
                     && (IW'(i_entry_index) < IW'(TABLE_DEPTH));
    assign n_rd_en = (r_state == S_PROBE) && !(r_low > r_high);

    stbs_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (i_entry_value),
        .i_rd_en   (n_rd_en),
        .i_rd_addr (n_mid),
        .o_rd_data (n_rd_data)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    // Search sequencer with its bounds and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_low       <= '0;
            r_high      <= '0;
        end else begin
            // The output register empties on a transfer unless a new result is loaded.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_accept && (t_op'(i_operation) == OP_SEARCH)) begin
                        r_low   <= '0;
                        r_high  <= BW'(n_count_sat) - BW'(1);
                        r_key   <= i_search_key;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_low > r_high) begin
                        r_res_found <= 1'b0;
                        r_res_index <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        r_mid   <= n_mid;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    priority if (n_rd_data == r_key) begin
                        r_res_found <= 1'b1;
                        r_res_index <= IDX_W'(r_mid);
                        r_state     <= S_DONE;
                    end else if (n_rd_data < r_key) begin
                        r_low   <= BW'(r_mid) + BW'(1);
                        r_state <= S_PROBE;
                    end else begin
                        r_high  <= BW'(r_mid) - BW'(1);
                        r_state <= S_PROBE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_found       <= r_res_found;
                        r_found_index <= r_res_index;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;

endmodule

/* sim/sorted_table_binary_search_core_tb.sv */
// Self-checking testbench for the sorted-table binary search core.
module sorted_table_binary_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int IDLE_PCT      = 18;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_EVERY    = 120;

    // One input transfer as it is offered to the core.
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] key;
    } t_table_item;

    // One search outcome.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_lookup_result;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 in_valid;
    logic                 dut_in_stall;
    logic [OP_W-1:0]      operation;
    logic [IDX_W-1:0]     entry_index;
    logic [VALUE_W-1:0]   entry_value;
    logic [VALUE_W-1:0]   search_key;
    logic                 dut_out_valid;
    logic                 out_stall;
    logic                 dut_found;
    logic [IDX_W-1:0]     dut_found_index;

    // Items waiting to be offered, and search outcomes waiting to arrive.
    t_table_item          pending_items[$];
    t_lookup_result       pending_lookups[$];
    t_table_item          offered_item;
    t_lookup_result       wanted;

    // Predictor state: the table and the register as the core should hold them.
    int                   table_copy [DEPTH];
    logic [CFG_W-1:0]     entry_count_copy;

    // The table as the stimulus generator expects it, used to pick keys that hit.
    logic [VALUE_W-1:0]   planned_table [DEPTH];
    logic [VALUE_W-1:0]   corner_vals [8];

    int                   cycle_cnt;
    logic                 calm;
    int                   errors;
    int                   n_writes;
    int                   n_searches;
    int                   n_results;
    int                   n_hits;
    int                   n_settings;
    int                   hold_left;
    int                   holds_done;

    sorted_table_binary_search_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (dut_in_stall),
        .i_operation   (operation),
        .i_entry_index (entry_index),
        .i_entry_value (entry_value),
        .i_search_key  (search_key),
        .o_out_valid   (dut_out_valid),
        .i_out_stall   (out_stall),
        .o_found       (dut_found),
        .o_found_index (dut_found_index)
    );

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Windows in which neither side idles nor stalls at random.
    assign calm = (cycle_cnt % 6000) < 1200;

    // Binary search over the predicted table, probing at the floor of the midpoint.
    function automatic t_lookup_result predict_lookup(input int key);
        int             lo;
        int             hi;
        int             mid;
        bit             done;
        t_lookup_result res;
        res  = '0;
        done = 1'b0;
        lo   = 0;
        hi   = (entry_count_copy > DEPTH) ? DEPTH - 1 : int'(entry_count_copy) - 1;
        while (!done && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (table_copy[mid] == key) begin
                res.found = 1'b1;
                res.index = mid[IDX_W-1:0];
                done      = 1'b1;
            end else if (table_copy[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    // Update the predictor for one accepted transfer. Every 10-bit index lies inside
    // the 1024-entry table, so no write is ever dropped.
    task automatic apply_item(input t_table_item item);
        if (item.op == OP_WRITE) begin
            table_copy[item.idx] = item.value;
            n_writes++;
        end else begin
            pending_lookups.push_back(predict_lookup(item.key));
            n_searches++;
        end
    endtask

    // Cycle counter and run limit.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Driver: offers queued items, holds the payload while stalled, idles at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !dut_in_stall) begin
                apply_item(offered_item);
            end
            if (!in_valid || !dut_in_stall) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    offered_item = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= offered_item.op;
                    entry_index <= offered_item.idx;
                    entry_value <= offered_item.value;
                    search_key  <= offered_item.key;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation and drives stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (dut_out_valid && !out_stall) begin
                if (pending_lookups.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual found=%0b index=%0d",
                             $time, dut_found, dut_found_index);
                end else begin
                    wanted = pending_lookups.pop_front();
                    n_results++;
                    if (wanted.found) begin
                        n_hits++;
                    end
                    if (dut_found !== wanted.found || dut_found_index !== wanted.index) begin
                        errors++;
                        $display("%0t: mismatch, expected found=%0b index=%0d,",
                                 $time, wanted.found, wanted.index,
                                 " actual found=%0b index=%0d",
                                 dut_found, dut_found_index);
                    end
                end
            end
            // A long hold-off while the sender still has plenty to offer fills the core up.
            if (hold_left == 0 && holds_done < 2 && n_results >= (holds_done + 1) * HOLD_EVERY
                    && pending_items.size() > 8) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic push_write(input int unsigned where, input logic [VALUE_W-1:0] v);
        t_table_item it;
        it.op    = OP_WRITE;
        it.idx   = where[IDX_W-1:0];
        it.value = v;
        it.key   = $urandom;
        planned_table[where[IDX_W-1:0]] = v;
        pending_items.push_back(it);
    endtask

    task automatic push_search(input logic [VALUE_W-1:0] k);
        t_table_item it;
        it.op    = OP_SEARCH;
        it.idx   = $urandom_range(0, DEPTH - 1);
        it.value = $urandom;
        it.key   = k;
        pending_items.push_back(it);
    endtask

    // Wait until every item is taken and every result is in, then let the core settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || pending_lookups.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only ever done with the core idle.
    task automatic set_entry_count(input int unsigned c);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        entry_count_copy = c[CFG_W-1:0];
        n_settings++;
        @(negedge clk);
    endtask

    // Write entries 0..n-1 with ascending random values (equal neighbours allowed).
    task automatic fill_sorted(input int n);
        longint level;
        longint step_max;
        step_max = (longint'(1) << 32) / (n + 1);
        level    = -(longint'(1) << 31) + $urandom_range(0, step_max[31:0]);
        for (int i = 0; i < n; i++) begin
            push_write(i, level[31:0]);
            level += $urandom_range(0, step_max[31:0]);
        end
    endtask

    // Mostly searches for present, neighbouring and random keys; some overwrites as noise.
    task automatic random_mix(input int n, input int eff);
        int                 roll;
        logic [VALUE_W-1:0] probe;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (eff > 0) begin
                probe = planned_table[$urandom_range(0, eff - 1)];
            end else begin
                probe = $urandom;
            end
            if (roll < 12) begin
                // An overwrite with a random value may break the ascending order.
                if (roll < 3 || eff == 0) begin
                    push_write($urandom_range(0, DEPTH - 1), $urandom);
                end else begin
                    push_write($urandom_range(0, eff - 1), $urandom);
                end
            end else if (roll < 60) begin
                push_search(probe);
            end else if (roll < 78) begin
                push_search(roll[0] ? probe + 1 : probe - 1);
            end else begin
                push_search($urandom);
            end
        end
    endtask

    // A small table freshly filled in order, then a random mix over it.
    task automatic small_phase(input int c);
        set_entry_count(c);
        fill_sorted(c);
        random_mix(20, c);
    endtask

    // Stimulus sequence.
    initial begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_valid         = 1'b0;
        operation        = OP_WRITE;
        entry_index      = '0;
        entry_value      = '0;
        search_key       = '0;
        out_stall        = 1'b0;
        cycle_cnt        = 0;
        errors           = 0;
        n_writes         = 0;
        n_searches       = 0;
        n_results        = 0;
        n_hits           = 0;
        n_settings       = 0;
        hold_left        = 0;
        holds_done       = 0;
        entry_count_copy = '0;
        corner_vals = '{32'h8000_0000, 32'hFFFF_FC18, 32'hFFFF_FFFF, 32'h0000_0000,
                        32'h0000_0001, 32'h0000_03E8, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // A zero count probes nothing, so every search misses.
        set_entry_count(0);
        push_search(32'h0000_0000);
        push_search(32'h8000_0000);
        for (int i = 0; i < 8; i++) begin
            push_write(i, corner_vals[i]);
        end
        push_write(DEPTH - 1, 32'h5A5A_A5A5);

        // A single entry: hit at index zero, and a miss above it.
        set_entry_count(1);
        push_search(corner_vals[0]);
        push_search(corner_vals[7]);

        // Eight extreme values, each found, then a gap key and an out-of-order entry.
        set_entry_count(8);
        for (int i = 0; i < 8; i++) begin
            push_search(corner_vals[i]);
        end
        push_search(32'd500);
        push_write(3, 32'h7FFF_FFFF);
        push_search(32'hFFFF_FFFF);
        push_search(32'h7FFF_FFFF);

        // Small tables first.
        small_phase(2);
        small_phase(3);
        small_phase(5);
        small_phase(7);
        small_phase(16);
        small_phase(31);

        // The whole table, then counts at and beyond the depth, which saturate.
        set_entry_count(DEPTH);
        fill_sorted(DEPTH);
        random_mix(50, DEPTH);
        set_entry_count(2047);
        random_mix(50, DEPTH);
        set_entry_count(DEPTH + 1);
        random_mix(30, DEPTH);
        set_entry_count(600);
        random_mix(30, 600);

        // More small tables, some of random size, and a final empty search range.
        small_phase(33);
        small_phase(48);
        for (int p = 0; p < 4; p++) begin
            small_phase($urandom_range(1, 48));
        end
        set_entry_count(0);
        random_mix(10, 0);

        wait_drained();
        $display("Run covered %0d table writes and %0d searches (%0d hits, %0d misses)",
                 n_writes, n_searches, n_hits, n_results - n_hits);
        $display("over %0d entry_count settings with %0d long receiver hold-offs;",
                 n_settings, holds_done, " %0d mismatches.", errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_table_ram.sv
hw/rtl/sorted_table_binary_search_core.sv
sim/sorted_table_binary_search_core_tb.sv
